FILE: design/ece_pkg.sv
// Shared types and constants for the epsilon closure engine.
package ece_pkg;

	// Sizing of the edge store
	localparam int MAX_NODES = 16;
	localparam int MAX_EDGES = 8;
	localparam int NODE_W    = 4;
	localparam int EIDX_W    = 3;
	localparam int CNT_W     = $clog2(MAX_EDGES + 1);
	localparam int DEPTH_W   = $clog2(MAX_NODES + 1);
	localparam int EDGE_AW   = NODE_W + EIDX_W;
	localparam int EDGE_N    = MAX_NODES * MAX_EDGES;

	// Configuration register
	localparam int              SC_W     = 5;
	localparam logic [SC_W-1:0] SC_RESET = 5'd16;

	// Command codes
	localparam int               CMD_W     = 2;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	// Result status codes
	localparam int              ST_W         = 3;
	localparam logic [ST_W-1:0] ST_MEMBER    = 3'd0;
	localparam logic [ST_W-1:0] ST_CLEARED   = 3'd1;
	localparam logic [ST_W-1:0] ST_ADDED     = 3'd2;
	localparam logic [ST_W-1:0] ST_REJECTED  = 3'd3;
	localparam logic [ST_W-1:0] ST_BAD_START = 3'd4;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// Classified operation handed from front to back
	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_ADD,
		OP_REJECT,
		OP_QUERY,
		OP_BAD_START
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [NODE_W-1:0] src;
		logic [NODE_W-1:0] tgt;
	} op_t;

endpackage

FILE: design/ece_ram.sv
// Generic single write port, single read port RAM with registered read data.
module ece_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/ece_front.sv
// Front end: command acceptance, range checks and the configuration register.
module ece_front (
	input  logic                        clk,
	input  logic                        arst_n,
	// command channel
	input  logic                        start,
	output logic                        busy,
	input  logic [ece_pkg::CMD_W-1:0]   command,
	input  logic [ece_pkg::NODE_W-1:0]  source_state,
	input  logic [ece_pkg::NODE_W-1:0]  target_state,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// queue side
	input  logic                        q_full,
	output logic                        q_push,
	output ece_pkg::op_t                q_op
);

	logic [ece_pkg::SC_W-1:0] state_count_q;
	logic                     accept;
	logic                     src_ok;
	logic                     tgt_ok;

	// Register write and readback
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_count_q <= ece_pkg::SC_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			state_count_q <= pwdata[ece_pkg::SC_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (!paddr[2]) begin
			prdata = {{(32 - ece_pkg::SC_W){1'b0}}, state_count_q};
		end
	end

	// States in use are those below state_count (capped by the 4-bit fields)
	assign busy   = q_full;
	assign accept = start && !q_full;
	assign src_ok = ece_pkg::SC_W'(source_state) < state_count_q;
	assign tgt_ok = ece_pkg::SC_W'(target_state) < state_count_q;

	// Classify the transaction; the unused command is dropped here
	always_comb begin
		q_push     = 1'b0;
		q_op.kind  = ece_pkg::OP_CLEAR;
		q_op.src   = source_state;
		q_op.tgt   = target_state;
		case (command)
			ece_pkg::CMD_CLEAR: begin
				q_push    = accept;
				q_op.kind = ece_pkg::OP_CLEAR;
			end
			ece_pkg::CMD_ADD: begin
				q_push    = accept;
				q_op.kind = (src_ok && tgt_ok) ? ece_pkg::OP_ADD : ece_pkg::OP_REJECT;
			end
			ece_pkg::CMD_QUERY: begin
				q_push    = accept;
				q_op.kind = src_ok ? ece_pkg::OP_QUERY : ece_pkg::OP_BAD_START;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

endmodule

FILE: design/ece_queue.sv
// Short operation queue between the front end and the walk engine.
module ece_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  ece_pkg::op_t push_op,
	output logic         full,
	input  logic         pop,
	output logic         valid,
	output ece_pkg::op_t head_op
);

	ece_pkg::op_t                 entry_q [ece_pkg::QUEUE_DEPTH];
	logic [ece_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [ece_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [ece_pkg::QCNT_W-1:0]   count_q;
	logic                         do_push;
	logic                         do_pop;

	assign full    = count_q == ece_pkg::QCNT_W'(ece_pkg::QUEUE_DEPTH);
	assign valid   = count_q != '0;
	assign head_op = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: design/ece_back.sv
// Back end: edge store updates and the depth-first closure walk.
module ece_back (
	input  logic                        clk,
	input  logic                        arst_n,
	// queue side
	input  logic                        op_valid,
	input  ece_pkg::op_t                op,
	output logic                        op_pop,
	// results
	output logic                        result_strobe,
	output logic [ece_pkg::NODE_W-1:0]  member_state,
	output logic                        last_flag,
	output logic [ece_pkg::ST_W-1:0]    status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_SCAN
	} state_t;

	state_t                          state_q;
	logic [ece_pkg::CNT_W-1:0]       edge_cnt_q [ece_pkg::MAX_NODES];
	logic [ece_pkg::MAX_NODES-1:0]   visited_q;
	logic [ece_pkg::NODE_W-1:0]      stack_q [ece_pkg::MAX_NODES];
	logic [ece_pkg::DEPTH_W-1:0]     depth_q;
	logic [ece_pkg::NODE_W-1:0]      cur_q;
	logic [ece_pkg::CNT_W-1:0]       len_q;
	logic [ece_pkg::CNT_W-1:0]       rd_idx_q;
	logic                            pend_q;
	logic                            res_strobe_q;
	logic [ece_pkg::NODE_W-1:0]      res_member_q;
	logic                            res_last_q;
	logic [ece_pkg::ST_W-1:0]        res_status_q;

	logic [ece_pkg::DEPTH_W-1:0]     depth_m1;
	logic [ece_pkg::NODE_W-1:0]      top_node;
	logic [ece_pkg::CNT_W-1:0]       src_cnt;
	logic                            add_ok;
	logic                            ram_we;
	logic                            ram_re;
	logic [ece_pkg::EDGE_AW-1:0]     ram_waddr;
	logic [ece_pkg::EDGE_AW-1:0]     ram_raddr;
	logic [ece_pkg::NODE_W-1:0]      ram_rdata;
	logic                            push_en;
	logic                            scan_done;
	logic                            res_fire;

	// Edge lists: row per source state, column per insertion slot
	ece_ram #(
		.WIDTH (ece_pkg::NODE_W),
		.DEPTH (ece_pkg::EDGE_N)
	) u_edge_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (op.tgt),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Walk control
	always_comb begin
		depth_m1  = depth_q - 1'b1;
		top_node  = stack_q[depth_m1[ece_pkg::NODE_W-1:0]];
		src_cnt   = edge_cnt_q[op.src];
		add_ok    = src_cnt < ece_pkg::CNT_W'(ece_pkg::MAX_EDGES);
		op_pop    = (state_q == S_IDLE) && op_valid;
		ram_we    = op_pop && (op.kind == ece_pkg::OP_ADD) && add_ok;
		ram_waddr = {op.src, src_cnt[ece_pkg::EIDX_W-1:0]};
		ram_re    = (state_q == S_SCAN) && (rd_idx_q < len_q);
		ram_raddr = {cur_q, rd_idx_q[ece_pkg::EIDX_W-1:0]};
		// read data from the previous cycle is a neighbor to examine
		push_en   = (state_q == S_SCAN) && pend_q && !visited_q[ram_rdata] &&
			(depth_q < ece_pkg::DEPTH_W'(ece_pkg::MAX_NODES));
		scan_done = (state_q == S_SCAN) && !pend_q && (rd_idx_q == len_q);
		// every popped operation but a query acknowledges at once
		res_fire  = (op_pop && (op.kind != ece_pkg::OP_QUERY)) || scan_done;
	end

	// Stack storage
	always_ff @(posedge clk) begin
		if (op_pop && (op.kind == ece_pkg::OP_QUERY)) begin
			stack_q[0] <= op.src;
		end
		if (push_en) begin
			stack_q[depth_q[ece_pkg::NODE_W-1:0]] <= ram_rdata;
		end
	end

	// Sequencer, edge counts, marks and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			for (int i = 0; i < ece_pkg::MAX_NODES; i++) begin
				edge_cnt_q[i] <= '0;
			end
			visited_q    <= '0;
			depth_q      <= '0;
			cur_q        <= '0;
			len_q        <= '0;
			rd_idx_q     <= '0;
			pend_q       <= 1'b0;
			res_strobe_q <= 1'b0;
			res_member_q <= '0;
			res_last_q   <= 1'b0;
			res_status_q <= ece_pkg::ST_MEMBER;
		end else begin
			res_strobe_q <= res_fire;
			case (state_q)
				S_IDLE: begin
					if (op_valid) begin
						res_member_q <= '0;
						res_last_q   <= 1'b1;
						case (op.kind)
							ece_pkg::OP_CLEAR: begin
								for (int i = 0; i < ece_pkg::MAX_NODES; i++) begin
									edge_cnt_q[i] <= '0;
								end
								res_status_q <= ece_pkg::ST_CLEARED;
							end
							ece_pkg::OP_ADD: begin
								if (add_ok) begin
									edge_cnt_q[op.src] <= src_cnt + 1'b1;
									res_status_q       <= ece_pkg::ST_ADDED;
								end else begin
									res_status_q <= ece_pkg::ST_REJECTED;
								end
							end
							ece_pkg::OP_REJECT: begin
								res_status_q <= ece_pkg::ST_REJECTED;
							end
							ece_pkg::OP_BAD_START: begin
								res_status_q <= ece_pkg::ST_BAD_START;
							end
							ece_pkg::OP_QUERY: begin
								visited_q <= ece_pkg::MAX_NODES'(1) << op.src;
								depth_q   <= ece_pkg::DEPTH_W'(1);
								state_q   <= S_POP;
							end
							default: ;
						endcase
					end
				end
				S_POP: begin
					cur_q    <= top_node;
					len_q    <= edge_cnt_q[top_node];
					depth_q  <= depth_m1;
					rd_idx_q <= '0;
					pend_q   <= 1'b0;
					state_q  <= S_SCAN;
				end
				S_SCAN: begin
					pend_q <= ram_re;
					if (ram_re) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (push_en) begin
						visited_q[ram_rdata] <= 1'b1;
						depth_q              <= depth_q + 1'b1;
					end
					// member leaves once all its neighbors are examined
					if (scan_done) begin
						res_member_q <= cur_q;
						res_last_q   <= depth_q == '0;
						res_status_q <= ece_pkg::ST_MEMBER;
						state_q      <= (depth_q == '0) ? S_IDLE : S_POP;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_strobe = res_strobe_q;
	assign member_state  = res_member_q;
	assign last_flag     = res_last_q;
	assign status        = res_status_q;

	// Stack never grows past the node count
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= ece_pkg::DEPTH_W'(ece_pkg::MAX_NODES))
		else $error("walk stack overflow");

	// A pop is only attempted with a non-empty stack
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP |-> depth_q != '0)
		else $error("pop from empty stack");

	// The node being expanded is always marked visited
	a_cur_visited: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> visited_q[cur_q])
		else $error("expanded node not marked");

	// Members only come out of the scan; acknowledgements are always last
	a_member_src: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe_q && (res_status_q == ece_pkg::ST_MEMBER) |-> $past(state_q == S_SCAN))
		else $error("member result outside scan");

	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe_q && (res_status_q != ece_pkg::ST_MEMBER) |-> res_last_q)
		else $error("acknowledgement not marked last");

endmodule

FILE: design/epsilon_closure_engine_unit.sv
// With the walk engine idle, an accepted start is written into the queue, popped by the
// engine and acknowledged through the result register. A query emits each member after
// its edges are scanned: the engine pops the state off the stack, reads its edge list and
// pushes each unvisited neighbor, so the walk is bound by the one-read-per-cycle edge RAM.
// Two transactions can be queued ahead of the walk engine; busy is high while the queue is full.
// Asynchronous reset empties all edge lists, clears the marks and sets state_count to 16;
// edge RAM contents stay undefined until written. Results are strobed one cycle each.
module epsilon_closure_engine_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// command channel
	input  logic                        start,
	output logic                        busy,
	input  logic [ece_pkg::CMD_W-1:0]   command,
	input  logic [ece_pkg::NODE_W-1:0]  source_state,
	input  logic [ece_pkg::NODE_W-1:0]  target_state,
	// result channel
	output logic                        result_strobe,
	output logic [ece_pkg::NODE_W-1:0]  member_state,
	output logic                        last_flag,
	output logic [ece_pkg::ST_W-1:0]    status,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic         q_full;
	logic         q_push;
	ece_pkg::op_t q_push_op;
	logic         q_valid;
	logic         q_pop;
	ece_pkg::op_t q_head_op;

	// Accept and classify
	ece_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.source_state (source_state),
		.target_state (target_state),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_op         (q_push_op)
	);

	// Decoupling queue
	ece_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (q_push_op),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.head_op (q_head_op)
	);

	// Execute
	ece_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.op_valid      (q_valid),
		.op            (q_head_op),
		.op_pop        (q_pop),
		.result_strobe (result_strobe),
		.member_state  (member_state),
		.last_flag     (last_flag),
		.status        (status)
	);

endmodule
